// ===== design/srs_pkg.sv =====
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants of the servo recipe sequencer
// field widths, opcodes, command codes and the duty reciprocal table
// ---------------------------------------------------------------------------
package srs_pkg;

   localparam int RECIPE_DEPTH = 32;
   localparam int CHANNELS     = 2;

   // recipe store holds one block of RECIPE_DEPTH bytes per channel
   localparam int IDX_W   = $clog2(RECIPE_DEPTH);
   localparam int IP_W    = $clog2(RECIPE_DEPTH + 1);
   localparam int STORE_DEPTH = CHANNELS * RECIPE_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int FUNC_W   = 2;
   localparam int CH_W     = 1;
   localparam int LADDR_W  = 5;
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 3;
   localparam int DUTY_W   = 16;
   localparam int WAIT_W   = 6;
   localparam int POS_W    = 5;
   localparam int OP_W     = 3;
   localparam int ARG_W    = 5;
   localparam int PWM_W    = 16;

   localparam logic [PWM_W-1:0] PWM_RESET = PWM_W'(20000);
   localparam logic [POS_W-1:0] POS_RESET = POS_W'(2);
   localparam logic [POS_W-1:0] POS_MIN   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(6);

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd2;

   localparam logic [CMD_W-1:0] CMD_BEGIN    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CONTINUE = 3'd5;

   localparam logic [OP_W-1:0] OP_MOV      = 3'b001;
   localparam logic [OP_W-1:0] OP_WAIT     = 3'b010;
   localparam logic [OP_W-1:0] OP_LOOP     = 3'b100;
   localparam logic [OP_W-1:0] OP_LOOP_END = 3'b101;

   // duty = (period * magic) >> DUTY_SHIFT, magic = ceil(2^21 / divisor),
   // exact for every 16-bit period and divisors from 9 up to 32
   localparam int MAGIC_W    = 18;
   localparam int DUTY_SHIFT = 21;
   localparam int PROD_W     = PWM_W + MAGIC_W;

   function automatic logic pos_in_range(input logic [POS_W-1:0] p);
      return (p >= POS_MIN) && (p <= POS_MAX);
   endfunction

   function automatic logic [MAGIC_W-1:0] duty_magic(input logic [POS_W-1:0] p);
      logic [MAGIC_W-1:0] m;
      case (p)
         5'd1: m = MAGIC_W'(209716);   // divide by 10
         5'd2: m = MAGIC_W'(190651);   // divide by 11
         5'd3: m = MAGIC_W'(174763);   // divide by 12
         5'd4: m = MAGIC_W'(149797);   // divide by 14
         5'd5: m = MAGIC_W'(131072);   // divide by 16
         5'd6: m = MAGIC_W'(116509);   // divide by 18
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== design/srs_req_if.sv =====
// ---------------------------------------------------------------------------
// srs_req_if: request channel of the servo recipe sequencer
// valid/ready handshake carrying one request word
// ---------------------------------------------------------------------------
interface srs_req_if import srs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [CH_W-1:0]     servo_select;
   logic [LADDR_W-1:0]  load_address;
   logic [BYTE_W-1:0]   recipe_byte;
   logic [CMD_W-1:0]    command;

   modport source (
      output valid, func, servo_select, load_address, recipe_byte, command,
      input  ready
   );

   modport sink (
      input  valid, func, servo_select, load_address, recipe_byte, command,
      output ready
   );

endinterface

// ===== design/srs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// srs_rsp_if: response channel of the servo recipe sequencer
// valid/ready handshake carrying one status word per request
// ---------------------------------------------------------------------------
interface srs_rsp_if import srs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     channel;
   logic                duty_valid;
   logic [DUTY_W-1:0]   duty;
   logic [WAIT_W-1:0]   wait_units;
   logic [POS_W-1:0]    position;
   logic                halted;
   logic                loop_error;
   logic                recipe_ended;

   modport source (
      output valid, channel, duty_valid, duty, wait_units, position, halted,
             loop_error, recipe_ended,
      input  ready
   );

   modport sink (
      input  valid, channel, duty_valid, duty, wait_units, position, halted,
             loop_error, recipe_ended,
      output ready
   );

endinterface

// ===== design/servo_recipe_sequencer.sv =====
// ---------------------------------------------------------------------------
// servo_recipe_sequencer: two-channel servo recipe sequencer
// loads recipe bytes, applies user commands and steps one instruction a word
// ---------------------------------------------------------------------------
// Takes one request word per clock while the response side is not stalled
// and returns exactly one response word for each, in order. The recipe bytes
// of both channels live in a 64 x 8 memory with a registered read port: a
// step word reads its instruction in the accept cycle and is executed in the
// execute stage, where the channel state (pointer, position, loop and pause)
// is updated; the instruction pointer is forwarded to the memory address so
// back-to-back steps on one channel run at full rate. The duty stage turns
// the position into a PWM compare value with one 16 x 18 reciprocal multiply.
// Delays are reported in 100 ms units, never waited out. The user must write
// pwm_period through csr_wr_en/csr_wr_data only while no word is in flight,
// not enforced by the block. A step reaching an unloaded slot is undefined.
// ---------------------------------------------------------------------------
module servo_recipe_sequencer import srs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   srs_req_if.sink          req_chan,
   srs_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [PWM_W-1:0] csr_wr_data
);

   // configuration
   logic [PWM_W-1:0]  pwm_period_ff;

   // per-channel state
   logic [IP_W-1:0]   ip_ff        [CHANNELS];
   logic [POS_W-1:0]  pos_ff       [CHANNELS];
   logic [ARG_W-1:0]  loops_ff     [CHANNELS];
   logic              active_ff    [CHANNELS];
   logic [IP_W-1:0]   start_ff     [CHANNELS];
   logic              paused_ff    [CHANNELS];

   // execute stage
   logic              s1_valid_ff;
   logic [CH_W-1:0]   s1_ch_ff;
   logic [FUNC_W-1:0] s1_func_ff;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [IP_W-1:0]   s1_ip_ff;

   // duty stage
   logic               s2_valid_ff;
   logic [CH_W-1:0]    s2_ch_ff;
   logic               s2_dv_ff;
   logic [MAGIC_W-1:0] s2_magic_ff;
   logic [WAIT_W-1:0]  s2_wait_ff;
   logic [POS_W-1:0]   s2_pos_ff;
   logic               s2_halt_ff;
   logic               s2_lerr_ff;
   logic               s2_end_ff;

   // output register
   logic               out_valid_ff;
   logic [CH_W-1:0]    out_ch_ff;
   logic               out_dv_ff;
   logic [DUTY_W-1:0]  out_duty_ff;
   logic [WAIT_W-1:0]  out_wait_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic               out_halt_ff;
   logic               out_lerr_ff;
   logic               out_end_ff;

   logic               out_free;
   logic               s2_free;
   logic               s1_free;
   logic               s1_fire;
   logic               accept;
   logic [IP_W-1:0]    fwd_ip;
   logic               store_wr_en;
   logic [STORE_AW-1:0] store_wr_addr;
   logic               store_rd_en;
   logic [STORE_AW-1:0] store_rd_addr;
   logic [BYTE_W-1:0]  store_rd_data;

   // execute stage results
   logic [POS_W-1:0]   cur_pos;
   logic [OP_W-1:0]    op;
   logic [ARG_W-1:0]   arg;
   logic [POS_W-1:0]   nudge_pos;
   logic [IP_W-1:0]    ip_in;
   logic [POS_W-1:0]   pos_in;
   logic [ARG_W-1:0]   loops_in;
   logic               active_in;
   logic [IP_W-1:0]    start_in;
   logic               paused_in;
   logic               dv_in;
   logic [POS_W-1:0]   duty_pos;
   logic [WAIT_W-1:0]  wait_in;
   logic               lerr_in;
   logic               end_in;
   logic [PROD_W-1:0]  duty_prod;

   // pipeline flow: a stage moves on when the one after it is empty or moving
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s1_fire  = s1_valid_ff && s2_free;
   assign accept   = req_chan.valid && s1_free;
   assign req_chan.ready = s1_free;

   // pointer as it will stand once the word in the execute stage retires
   always_comb begin
      if (s1_valid_ff && (s1_ch_ff == req_chan.servo_select)) begin
         fwd_ip = ip_in;
      end else begin
         fwd_ip = ip_ff[req_chan.servo_select];
      end
   end

   assign store_wr_en   = accept && (req_chan.func == FUNC_LOAD) &&
                          ($unsigned(req_chan.load_address) < RECIPE_DEPTH);
   assign store_wr_addr = {req_chan.servo_select, IDX_W'(req_chan.load_address)};
   assign store_rd_en   = accept && (req_chan.func == FUNC_STEP);
   assign store_rd_addr = {req_chan.servo_select, fwd_ip[IDX_W-1:0]};

   srs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_recipe_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (req_chan.recipe_byte),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   assign cur_pos = pos_ff[s1_ch_ff];
   assign op      = store_rd_data[BYTE_W-1 -: OP_W];
   assign arg     = store_rd_data[ARG_W-1:0];

   always_comb begin
      ip_in     = s1_ip_ff;
      pos_in    = cur_pos;
      loops_in  = loops_ff[s1_ch_ff];
      active_in = active_ff[s1_ch_ff];
      start_in  = start_ff[s1_ch_ff];
      paused_in = paused_ff[s1_ch_ff];
      dv_in     = 1'b0;
      duty_pos  = '0;
      wait_in   = '0;
      lerr_in   = 1'b0;
      end_in    = 1'b0;
      nudge_pos = '0;
      case (s1_func_ff)
         FUNC_CMD: begin
            case (s1_cmd_ff)
               CMD_BEGIN: begin
                  ip_in     = '0;
                  paused_in = 1'b0;
               end
               CMD_PAUSE: begin
                  paused_in = 1'b1;
               end
               CMD_LEFT: begin
                  nudge_pos = cur_pos - 1'b1;
                  dv_in     = pos_in_range(nudge_pos);
                  duty_pos  = nudge_pos;
                  if ((cur_pos <= POS_MAX) && (cur_pos > POS_MIN)) begin
                     pos_in = nudge_pos;
                  end
               end
               CMD_RIGHT: begin
                  nudge_pos = cur_pos + 1'b1;
                  dv_in     = pos_in_range(nudge_pos);
                  duty_pos  = nudge_pos;
                  if ((cur_pos < POS_MAX) && (cur_pos >= POS_MIN)) begin
                     pos_in = nudge_pos;
                  end
               end
               CMD_CONTINUE: begin
                  paused_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         FUNC_STEP: begin
            if (!paused_ff[s1_ch_ff]) begin
               if ($unsigned(s1_ip_ff) >= RECIPE_DEPTH) begin
                  paused_in = 1'b1;
                  end_in    = 1'b1;
               end else begin
                  case (op)
                     OP_MOV: begin
                        dv_in    = pos_in_range(arg);
                        duty_pos = arg;
                        if (cur_pos > arg) begin
                           wait_in = WAIT_W'(cur_pos - arg);
                        end else begin
                           wait_in = WAIT_W'(arg - cur_pos);
                        end
                        pos_in = arg;
                        ip_in  = s1_ip_ff + 1'b1;
                     end
                     OP_WAIT: begin
                        wait_in = WAIT_W'(arg) + 1'b1;
                        ip_in   = s1_ip_ff + 1'b1;
                     end
                     OP_LOOP: begin
                        ip_in = s1_ip_ff + 1'b1;
                        if (active_ff[s1_ch_ff]) begin
                           // nested loop stops the channel
                           lerr_in   = 1'b1;
                           paused_in = 1'b1;
                        end else begin
                           active_in = 1'b1;
                           loops_in  = arg;
                           start_in  = s1_ip_ff + 1'b1;
                        end
                     end
                     OP_LOOP_END: begin
                        if (active_ff[s1_ch_ff] && (loops_ff[s1_ch_ff] != '0)) begin
                           ip_in    = start_ff[s1_ch_ff];
                           loops_in = loops_ff[s1_ch_ff] - 1'b1;
                        end else begin
                           active_in = 1'b0;
                           ip_in     = s1_ip_ff + 1'b1;
                        end
                     end
                     default: begin
                        // end marker or unknown opcode, pointer holds
                        paused_in = 1'b1;
                        end_in    = 1'b1;
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign duty_prod = PROD_W'(pwm_period_ff) * PROD_W'(s2_magic_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= PWM_RESET;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            ip_ff[c]     <= '0;
            pos_ff[c]    <= POS_RESET;
            loops_ff[c]  <= '0;
            active_ff[c] <= 1'b0;
            start_ff[c]  <= '0;
            paused_ff[c] <= 1'b1;
         end
      end else begin
         if (csr_wr_en) begin
            pwm_period_ff <= csr_wr_data;
         end
         if (s1_free) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s2_valid_ff;
         end
         if (s1_fire) begin
            ip_ff[s1_ch_ff]     <= ip_in;
            pos_ff[s1_ch_ff]    <= pos_in;
            loops_ff[s1_ch_ff]  <= loops_in;
            active_ff[s1_ch_ff] <= active_in;
            start_ff[s1_ch_ff]  <= start_in;
            paused_ff[s1_ch_ff] <= paused_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff   <= req_chan.servo_select;
         s1_func_ff <= req_chan.func;
         s1_cmd_ff  <= req_chan.command;
         s1_ip_ff   <= fwd_ip;
      end
      if (s1_fire) begin
         s2_ch_ff    <= s1_ch_ff;
         s2_dv_ff    <= dv_in;
         s2_magic_ff <= duty_magic(duty_pos);
         s2_wait_ff  <= wait_in;
         s2_pos_ff   <= pos_in;
         s2_halt_ff  <= paused_in;
         s2_lerr_ff  <= lerr_in;
         s2_end_ff   <= end_in;
      end
      if (s2_valid_ff && out_free) begin
         out_ch_ff   <= s2_ch_ff;
         out_dv_ff   <= s2_dv_ff;
         out_duty_ff <= s2_dv_ff ? DUTY_W'(duty_prod >> DUTY_SHIFT) : '0;
         out_wait_ff <= s2_wait_ff;
         out_pos_ff  <= s2_pos_ff;
         out_halt_ff <= s2_halt_ff;
         out_lerr_ff <= s2_lerr_ff;
         out_end_ff  <= s2_end_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.channel      = out_ch_ff;
   assign rsp_chan.duty_valid   = out_dv_ff;
   assign rsp_chan.duty         = out_duty_ff;
   assign rsp_chan.wait_units   = out_wait_ff;
   assign rsp_chan.position     = out_pos_ff;
   assign rsp_chan.halted       = out_halt_ff;
   assign rsp_chan.loop_error   = out_lerr_ff;
   assign rsp_chan.recipe_ended = out_end_ff;

endmodule

// ===== design/srs_ram.sv =====
// ---------------------------------------------------------------------------
// srs_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/srs_checker.sv =====
// ---------------------------------------------------------------------------
// srs_assertions: port-level checks of the servo recipe sequencer
// watches the response channel over time, bound to the top level
// ---------------------------------------------------------------------------
module srs_assertions import srs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_duty_valid,
   input  logic [DUTY_W-1:0] rsp_duty,
   input  logic [WAIT_W-1:0] rsp_wait_units,
   input  logic              rsp_halted,
   input  logic              rsp_loop_error,
   input  logic              rsp_recipe_ended
);

   // a word offered on the response side stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_duty_valid |-> rsp_duty == '0)
      else $error("duty not zero without a new compare value");

   a_wait_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_units <= WAIT_W'(32))
      else $error("wait beyond the longest instruction delay");

   // loop errors and recipe ends always leave the channel paused
   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_loop_error || rsp_recipe_ended) |-> rsp_halted)
      else $error("stopping condition without pause");

endmodule

bind servo_recipe_sequencer srs_assertions u_srs_assertions (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_duty_valid   (rsp_chan.duty_valid),
   .rsp_duty         (rsp_chan.duty),
   .rsp_wait_units   (rsp_chan.wait_units),
   .rsp_halted       (rsp_chan.halted),
   .rsp_loop_error   (rsp_chan.loop_error),
   .rsp_recipe_ended (rsp_chan.recipe_ended)
);
